FILE: rtl/c8_pkg.sv
// Package for the CHIP-8 interpreter core: payload structs, op codes,
// sequencer states, status codes and the font table. No dependencies.
`default_nettype none
package c8_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int PROGRAM_START = 512;
  localparam int STACK_DEPTH   = 16;
  localparam int FONT_BYTES    = 80;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_EXEC  = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_RDMEM = 3'd3;
  localparam logic [2:0] OP_RDROW = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNK   = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_UNDER = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  random_byte;
    logic [15:0] key_states;
    logic [4:0]  row_sel;
  } c8_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] prog_counter;
    logic [15:0] index_value;
    logic [63:0] read_value;
    logic        sound_on;
  } c8_out_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_FETCH0, S_FETCH1, S_FETCH2, S_DEC,
    S_DRAW_RD, S_DRAW_WAIT, S_DRAW_WR, S_CLS,
    S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WAIT, S_LOAD_WR,
    S_RDMEM_WAIT, S_RDROW_WAIT, S_OUT
  } c8_state_t;

  function automatic logic [7:0] font_byte(input logic [6:0] a);
    logic [7:0] f [FONT_BYTES];
    f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
          8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
          8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
          8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
          8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
          8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
          8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
          8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
    if (a < 7'(FONT_BYTES)) font_byte = f[a];
    else font_byte = 8'h00;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/c8_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/chip8_interpreter_core.sv
// CHIP-8 interpreter core: one sequencer over a 4096x8 main memory and a
// 32x64 frame memory, both synchronous RAMs with registered read data.
// Execute fetches and decodes, then steps draw/clear per row, FX33 per digit
// and FX55/FX65 per register. Load, tick and reads skip these steps.
// One word at a time; the next word is taken the cycle after the result is.
// Reset: a clearing pass writes font, memory and frame first.
`default_nettype none
module chip8_interpreter_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire c8_pkg::c8_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output c8_pkg::c8_out_t      out_data
);
  import c8_pkg::*;

  c8_state_t state, state_next;
  c8_in_t    req;
  logic [7:0]  v [16];
  logic [11:0] stk [STACK_DEPTH];
  logic [4:0]  sp;
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [7:0]  dt, st;
  logic [11:0] cnt;
  logic [7:0]  hi;
  logic [15:0] w;
  logic [1:0]  status;
  logic [63:0] rv;
  logic        hit;
  logic [63:0] mask;

  logic        m_we, f_we;
  logic [11:0] m_addr;
  logic [7:0]  m_wd, m_rd;
  logic [4:0]  f_addr;
  logic [63:0] f_wd, f_rd;

  c8_ram #(.WIDTH(8),  .DEPTH(MEM_BYTES))     u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
  c8_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_frame (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

  logic [3:0] x, y, n;
  logic [7:0] nn, vx, vy;
  logic [11:0] nnn;
  assign x = w[11:8];
  assign y = w[7:4];
  assign n = w[3:0];
  assign nn = w[7:0];
  assign nnn = w[11:0];
  assign vx = v[x];
  assign vy = v[y];

  logic [5:0] x0;
  logic [4:0] y0;
  logic [127:0] rot;
  assign x0 = vx[5:0];
  assign y0 = vy[4:0];
  always_comb begin
    rot = {m_rd, 120'd0} >> x0;
    mask = rot[127:64] | rot[63:0];
  end

  logic [3:0] bcd_h, bcd_t, bcd_o;
  logic [7:0] bcd_r;
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
    bcd_r = vx - 8'(bcd_h) * 8'd100;
    bcd_t = 4'((16'(bcd_r) * 16'd205) >> 11);
    bcd_o = 4'(bcd_r - 8'(bcd_t) * 8'd10);
  end

  always_comb begin
    m_we = 1'b0; m_addr = cnt; m_wd = 8'h00;
    f_we = 1'b0; f_addr = cnt[4:0]; f_wd = '0;
    state_next = state;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_INIT: begin
        m_we = 1'b1; m_addr = cnt; m_wd = font_byte(7'(cnt[11:7] == 5'd0 ? cnt[6:0] : 7'h7F));
        f_we = (cnt < 12'(SCREEN_HEIGHT));
        if (cnt == 12'(MEM_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        m_addr = in_data.addr;
        f_addr = in_data.row_sel;
        if (in_valid) begin
          case (in_data.op)
            OP_LOAD: begin m_we = 1'b1; m_wd = in_data.data; state_next = S_OUT; end
            OP_EXEC: state_next = S_FETCH0;
            OP_RDMEM: state_next = S_RDMEM_WAIT;
            OP_RDROW: state_next = S_RDROW_WAIT;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_FETCH0: begin m_addr = pc; state_next = S_FETCH1; end
      S_FETCH1: begin m_addr = pc + 12'd1; state_next = S_FETCH2; end
      S_FETCH2: state_next = S_DEC;
      S_DEC: begin
        state_next = S_OUT;
        case (w[15:12])
          4'h0: if (w == 16'h00E0) state_next = S_CLS;
          4'hD: if (n != 4'd0) state_next = S_DRAW_RD;
          4'hF: begin
            if (nn == 8'h33) state_next = S_BCD;
            else if (nn == 8'h55) state_next = S_STORE;
            else if (nn == 8'h65) state_next = S_LOAD_RD;
          end
          default: ;
        endcase
      end
      S_CLS: begin
        f_we = 1'b1;
        if (cnt[4:0] == 5'(SCREEN_HEIGHT - 1)) state_next = S_OUT;
      end
      S_DRAW_RD: begin
        m_addr = 12'(ireg + 16'(cnt));
        f_addr = 5'(y0 + 5'(cnt));
        state_next = S_DRAW_WAIT;
      end
      S_DRAW_WAIT: begin
        m_addr = 12'(ireg + 16'(cnt));
        f_addr = 5'(y0 + 5'(cnt));
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        f_addr = 5'(y0 + 5'(cnt));
        f_we = 1'b1; f_wd = f_rd ^ mask;
        state_next = (cnt == 12'(n) - 12'd1) ? S_OUT : S_DRAW_RD;
      end
      S_BCD: begin
        m_we = 1'b1; m_addr = 12'(ireg + 16'(cnt));
        m_wd = (cnt == 12'd0) ? 8'(bcd_h) : (cnt == 12'd1) ? 8'(bcd_t) : 8'(bcd_o);
        if (cnt == 12'd2) state_next = S_OUT;
      end
      S_STORE: begin
        m_we = 1'b1; m_addr = 12'(ireg + 16'(cnt)); m_wd = v[cnt[3:0]];
        if (cnt[3:0] == x) state_next = S_OUT;
      end
      S_LOAD_RD: begin m_addr = 12'(ireg + 16'(cnt)); state_next = S_LOAD_WAIT; end
      S_LOAD_WAIT: begin m_addr = 12'(ireg + 16'(cnt)); state_next = S_LOAD_WR; end
      S_LOAD_WR: state_next = (cnt[3:0] == x) ? S_OUT : S_LOAD_RD;
      S_RDMEM_WAIT: state_next = S_OUT;
      S_RDROW_WAIT: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; sp <= '0; ireg <= '0; pc <= 12'(PROGRAM_START);
      dt <= '0; st <= '0;
      for (int k = 0; k < 16; k++) v[k] <= 8'h00;
    end else begin
      case (state)
        S_INIT: cnt <= (cnt == 12'(MEM_BYTES - 1)) ? 12'd0 : cnt + 12'd1;
        S_IDLE: if (in_valid) begin
          req <= in_data; status <= ST_OK; rv <= '0; cnt <= '0;
          if (in_data.op == OP_TICK) begin
            if (dt != 8'd0) dt <= dt - 8'd1;
            if (st != 8'd0) st <= st - 8'd1;
          end
        end
        S_FETCH1: hi <= m_rd;
        S_FETCH2: w <= {hi, m_rd};
        S_DEC: begin
          pc <= pc + 12'd2;
          cnt <= '0; hit <= 1'b0;
          case (w[15:12])
            4'h0: begin
              if (w == 16'h00EE) begin
                if (sp == 5'd0) status <= ST_UNDER;
                else begin sp <= sp - 5'd1; pc <= stk[4'(sp - 5'd1)]; end
              end else if (w != 16'h00E0) status <= ST_UNK;
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (sp >= 5'(STACK_DEPTH)) status <= ST_OVER;
              else begin stk[4'(sp)] <= pc + 12'd2; sp <= sp + 5'd1; pc <= nnn; end
            end
            4'h3: if (vx == nn) pc <= pc + 12'd4;
            4'h4: if (vx != nn) pc <= pc + 12'd4;
            4'h5: if (n != 4'd0) status <= ST_UNK; else if (vx == vy) pc <= pc + 12'd4;
            4'h6: v[x] <= nn;
            4'h7: v[x] <= vx + nn;
            4'h8: case (n)
              4'h0: v[x] <= vy;
              4'h1: v[x] <= vx | vy;
              4'h2: v[x] <= vx & vy;
              4'h3: v[x] <= vx ^ vy;
              4'h4: begin
                if (x != 4'hF) v[x] <= vx + vy;
                v[15] <= 8'({1'b0, vx} + {1'b0, vy} > 9'd255);
              end
              4'h5: begin
                if (x != 4'hF) v[x] <= vx - vy;
                v[15] <= 8'(vx >= vy);
              end
              4'h6: begin
                if (x != 4'hF) v[x] <= vx >> 1;
                v[15] <= 8'(vx[0]);
              end
              4'h7: begin
                if (x != 4'hF) v[x] <= vy - vx;
                v[15] <= 8'(vy >= vx);
              end
              4'hE: begin
                if (x != 4'hF) v[x] <= vx << 1;
                v[15] <= 8'(vx[7]);
              end
              default: status <= ST_UNK;
            endcase
            4'h9: if (n != 4'd0) status <= ST_UNK; else if (vx != vy) pc <= pc + 12'd4;
            4'hA: ireg <= 16'(nnn);
            4'hB: pc <= nnn + 12'(v[0]);
            4'hC: v[x] <= req.random_byte & nn;
            4'hD: if (n == 4'd0) v[15] <= 8'h00;
            4'hE: begin
              if (nn == 8'h9E) begin if (req.key_states[vx[3:0]]) pc <= pc + 12'd4; end
              else if (nn == 8'hA1) begin if (!req.key_states[vx[3:0]]) pc <= pc + 12'd4; end
              else status <= ST_UNK;
            end
            default: case (nn)
              8'h07: v[x] <= dt;
              8'h0A: ;
              8'h15: dt <= vx;
              8'h18: st <= vx;
              8'h1E: ireg <= ireg + 16'(vx);
              8'h29: ireg <= 16'(vx) * 16'd5;
              8'h33, 8'h55, 8'h65: ;
              default: status <= ST_UNK;
            endcase
          endcase
        end
        S_CLS, S_BCD, S_STORE, S_LOAD_WR: cnt <= cnt + 12'd1;
        S_DRAW_WR: begin
          cnt <= cnt + 12'd1;
          if ((f_rd & mask) != 64'd0) hit <= 1'b1;
          if (cnt == 12'(n) - 12'd1) v[15] <= 8'(hit || ((f_rd & mask) != 64'd0));
        end
        S_RDMEM_WAIT: rv <= 64'(m_rd);
        S_RDROW_WAIT: rv <= f_rd;
        default: ;
      endcase
      if (state == S_LOAD_WR) v[cnt[3:0]] <= m_rd;
    end
  end

  assign out_data.status = status;
  assign out_data.prog_counter = pc;
  assign out_data.index_value = ireg;
  assign out_data.read_value = rv;
  assign out_data.sound_on = (st != 8'd0);

  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready and valid together");
  assert property (@(posedge clk) disable iff (rst) sp <= 5'(STACK_DEPTH))
    else $error("stack pointer out of range");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result not held");
endmodule
`default_nettype wire
